// ----- hdl/ytb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytb_pkg
// Shared types, constants and helpers of the YUV to BGRA pixel pair converter.
// ----------------------------------------------------------------------------
package ytb_pkg;

    // Pipeline depth: unpack, multiply, sum, saturate/output
    localparam int NUM_STAGES = 4;

    // Configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_PIXEL_FORMAT = 2'd0;

    // Format codes; bit 1 set selects the NV12 order
    localparam logic [1:0] FMT_YUYV     = 2'd0;
    localparam logic [1:0] FMT_UYVY     = 2'd1;
    localparam int         FMT_NV12_BIT = 1;

    // BT.601 integer coefficients and offsets
    localparam logic signed [17:0] K_Y   = 18'sd298;
    localparam logic signed [17:0] K_BU  = 18'sd516;
    localparam logic signed [17:0] K_GU  = 18'sd100;
    localparam logic signed [17:0] K_GV  = 18'sd208;
    localparam logic signed [17:0] K_RV  = 18'sd409;
    localparam logic signed [18:0] RND   = 19'sd128;
    localparam logic signed [8:0]  Y_OFS = 9'sd16;
    localparam logic signed [8:0]  C_OFS = 9'sd128;
    localparam logic [7:0]         CH_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic       second_present;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       second_valid;
    } t_out_item;

    // Stage 1: offset-removed luma and chroma
    typedef struct packed {
        logic signed [8:0] c0;
        logic signed [8:0] c1;
        logic signed [8:0] d;
        logic signed [8:0] e;
        logic              second;
    } t_s1;

    // Stage 2: products
    typedef struct packed {
        logic signed [17:0] p_y0;
        logic signed [17:0] p_y1;
        logic signed [17:0] p_b;
        logic signed [17:0] p_g;
        logic signed [17:0] p_r;
        logic               second;
    } t_s2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  out_valid;
    } t_pipe_ctl;

    // floor(s / 256) clamped to 0..255
    function automatic logic [7:0] sat8(input logic signed [18:0] s);
        logic [7:0] r;
        if (s[18]) begin
            r = 8'd0;
        end else if (|s[17:16]) begin
            r = CH_MAX;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

endpackage

// ----- hdl/ytb_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytb_ifs
// Valid/ready stream interfaces for input byte groups and output pixel pairs.
// ----------------------------------------------------------------------------
interface ytb_in_if;
    logic              valid;
    logic              ready;
    ytb_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ytb_out_if;
    logic               valid;
    logic               ready;
    ytb_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/yuv_to_bgra_pixel_pair.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_bgra_pixel_pair
// BT.601 studio-range YCbCr to BGR converter, one pixel pair per transfer.
//
//   channel   direction  handshake        payload
//   i_pix     in         valid/ready      four raw bytes, second_present
//   o_pix     out        valid/ready      BGR of both pixels, second_valid
//   APB       in         psel/penable     pixel_format at address 0
//
// One pixel pair per cycle sustained while o_pix is ready; stages are unpack,
// multiply, sum, saturate into the output register.
// i_rst_n is synchronous and clears the valid bits and pixel_format.
// A stall on o_pix holds the full stages; empty stages keep filling, so
// i_pix.ready stays high until every stage holds an item.
// ----------------------------------------------------------------------------
module yuv_to_bgra_pixel_pair (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ytb_in_if.sink                             i_pix,
    ytb_out_if.source                          o_pix,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ytb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ytb_pkg::PDATA_W-1:0]   pwdata,
    output      logic [ytb_pkg::PDATA_W-1:0]   prdata,
    output      logic                          pready
);

    logic [1:0]         r_fmt;
    ytb_pkg::t_pipe_ctl ctl;
    ytb_pkg::t_s1       s1;
    ytb_pkg::t_s2       s2;
    ytb_pkg::t_bgr      bgr0;
    ytb_pkg::t_bgr      bgr1;
    logic               r_sec3;
    logic               r_sec4;
    logic               in_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= ytb_pkg::FMT_YUYV;
        end else if (psel && penable && pwrite && (paddr == ytb_pkg::ADDR_PIXEL_FORMAT)) begin
            r_fmt <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ytb_pkg::ADDR_PIXEL_FORMAT)
                  ? {{(ytb_pkg::PDATA_W-2){1'b0}}, r_fmt} : '0;

    ytb_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_pix.ready),
        .o_ctl       (ctl)
    );

    assign i_pix.ready = in_ready;

    ytb_unpack u_unpack (
        .i_clk  (i_clk),
        .i_load (ctl.load[0]),
        .i_fmt  (r_fmt),
        .i_item (i_pix.data),
        .o_s1   (s1)
    );

    ytb_terms u_terms (
        .i_clk  (i_clk),
        .i_load (ctl.load[1]),
        .i_s1   (s1),
        .o_s2   (s2)
    );

    // Advance the second-pixel flag alongside the sum and output stages
    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_sec3 <= s2.second;
        end
        if (ctl.load[3]) begin
            r_sec4 <= r_sec3;
        end
    end

    ytb_pixel u_pixel_first (
        .i_clk      (i_clk),
        .i_load_sum (ctl.load[2]),
        .i_load_sat (ctl.load[3]),
        .i_p_y      (s2.p_y0),
        .i_p_b      (s2.p_b),
        .i_p_g      (s2.p_g),
        .i_p_r      (s2.p_r),
        .i_keep     (1'b1),
        .o_bgr      (bgr0)
    );

    ytb_pixel u_pixel_second (
        .i_clk      (i_clk),
        .i_load_sum (ctl.load[2]),
        .i_load_sat (ctl.load[3]),
        .i_p_y      (s2.p_y1),
        .i_p_b      (s2.p_b),
        .i_p_g      (s2.p_g),
        .i_p_r      (s2.p_r),
        .i_keep     (r_sec3),
        .o_bgr      (bgr1)
    );

    assign o_pix.valid             = ctl.out_valid;
    assign o_pix.data.blue_first   = bgr0.blue;
    assign o_pix.data.green_first  = bgr0.green;
    assign o_pix.data.red_first    = bgr0.red;
    assign o_pix.data.blue_second  = bgr1.blue;
    assign o_pix.data.green_second = bgr1.green;
    assign o_pix.data.red_second   = bgr1.red;
    assign o_pix.data.second_valid = r_sec4;

endmodule
`default_nettype wire

// ----- hdl/ytb_pipe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytb_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module ytb_pipe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    input  wire logic                i_out_ready,
    output      ytb_pkg::t_pipe_ctl  o_ctl
);

    localparam int NS = ytb_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] adv;

    // A stage advances when empty or when its successor advances
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready      = adv[0];
    assign o_ctl.load      = adv;
    assign o_ctl.out_valid = r_vld[NS-1];

endmodule
`default_nettype wire

// ----- hdl/ytb_unpack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytb_unpack
// Byte order decode and removal of the luma and chroma offsets.
// ----------------------------------------------------------------------------
module ytb_unpack (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic [1:0]        i_fmt,
    input  wire ytb_pkg::t_in_item i_item,
    output      ytb_pkg::t_s1      o_s1
);

    logic [7:0]   y0;
    logic [7:0]   y1;
    logic [7:0]   u;
    logic [7:0]   v;
    ytb_pkg::t_s1 r_s1;
    ytb_pkg::t_s1 n_s1;

    always_comb begin
        if (i_fmt[ytb_pkg::FMT_NV12_BIT]) begin
            y0 = i_item.byte_zero;
            y1 = i_item.byte_one;
            u  = i_item.byte_two;
            v  = i_item.byte_three;
        end else if (i_fmt == ytb_pkg::FMT_UYVY) begin
            u  = i_item.byte_zero;
            y0 = i_item.byte_one;
            v  = i_item.byte_two;
            y1 = i_item.byte_three;
        end else begin
            y0 = i_item.byte_zero;
            u  = i_item.byte_one;
            y1 = i_item.byte_two;
            v  = i_item.byte_three;
        end
        n_s1.c0     = $signed({1'b0, y0}) - ytb_pkg::Y_OFS;
        n_s1.c1     = $signed({1'b0, y1}) - ytb_pkg::Y_OFS;
        n_s1.d      = $signed({1'b0, u}) - ytb_pkg::C_OFS;
        n_s1.e      = $signed({1'b0, v}) - ytb_pkg::C_OFS;
        n_s1.second = i_item.second_present;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule
`default_nettype wire

// ----- hdl/ytb_terms.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytb_terms
// Coefficient products: two luma terms and the shared chroma terms.
// ----------------------------------------------------------------------------
module ytb_terms (
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire ytb_pkg::t_s1 i_s1,
    output      ytb_pkg::t_s2 o_s2
);

    ytb_pkg::t_s2 r_s2;
    ytb_pkg::t_s2 n_s2;

    always_comb begin
        n_s2.p_y0   = ytb_pkg::K_Y * 18'(i_s1.c0);
        n_s2.p_y1   = ytb_pkg::K_Y * 18'(i_s1.c1);
        n_s2.p_b    = ytb_pkg::K_BU * 18'(i_s1.d);
        n_s2.p_g    = ytb_pkg::K_GU * 18'(i_s1.d) + ytb_pkg::K_GV * 18'(i_s1.e);
        n_s2.p_r    = ytb_pkg::K_RV * 18'(i_s1.e);
        n_s2.second = i_s1.second;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

// ----- hdl/ytb_pixel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytb_pixel
// Channel sums and saturation for one pixel, two register stages.
// ----------------------------------------------------------------------------
module ytb_pixel (
    input  wire logic               i_clk,
    input  wire logic               i_load_sum,
    input  wire logic               i_load_sat,
    input  wire logic signed [17:0] i_p_y,
    input  wire logic signed [17:0] i_p_b,
    input  wire logic signed [17:0] i_p_g,
    input  wire logic signed [17:0] i_p_r,
    input  wire logic               i_keep,
    output      ytb_pkg::t_bgr      o_bgr
);

    logic signed [18:0] r_sum_b;
    logic signed [18:0] r_sum_g;
    logic signed [18:0] r_sum_r;
    ytb_pkg::t_bgr      r_bgr;
    ytb_pkg::t_bgr      n_bgr;

    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_sum_b <= 19'(i_p_y) + 19'(i_p_b) + ytb_pkg::RND;
            r_sum_g <= 19'(i_p_y) - 19'(i_p_g) + ytb_pkg::RND;
            r_sum_r <= 19'(i_p_y) + 19'(i_p_r) + ytb_pkg::RND;
        end
    end

    // Drop the channels to zero for an absent pixel
    always_comb begin
        if (i_keep) begin
            n_bgr.blue  = ytb_pkg::sat8(r_sum_b);
            n_bgr.green = ytb_pkg::sat8(r_sum_g);
            n_bgr.red   = ytb_pkg::sat8(r_sum_r);
        end else begin
            n_bgr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_sat) begin
            r_bgr <= n_bgr;
        end
    end

    assign o_bgr = r_bgr;

endmodule
`default_nettype wire

// ----- sim/tb_yuv_to_bgra_pixel_pair.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv_to_bgra_pixel_pair
// Self-checking bench for the YCbCr to BGR pixel pair converter. A scoreboard
// computes the BT.601 integer colors of every accepted byte group under the
// current pixel format, and compares them in order with the output pairs.
// The bench walks through all format codes, corner byte patterns and random
// groups, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_yuv_to_bgra_pixel_pair;

    // Codes without a name in the package
    localparam logic [1:0] FMT_NV12  = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;  // unused code, decodes as NV12

    localparam int NUM_PHASES       = 12;
    localparam int RANDOM_PER_PHASE = 117;
    localparam int CALM_PHASES      = 2;

    class pair_scoreboard;
        ytb_pkg::t_out_item pending_pairs[$];
        logic [1:0]         pixel_format;
        int                 errors;
        int                 n_checked;
        int                 n_lone;

        function logic [7:0] clamp_channel(int sum);
            int q;
            q = sum >>> 8;
            if (q < 0) return 8'd0;
            if (q > 255) return 8'd255;
            return q[7:0];
        endfunction

        function ytb_pkg::t_bgr pixel_bgr(int luma, int d, int e);
            ytb_pkg::t_bgr px;
            int            c;
            c = luma - 16;
            px.blue  = clamp_channel(298 * c + 516 * d + 128);
            px.green = clamp_channel(298 * c - 100 * d - 208 * e + 128);
            px.red   = clamp_channel(298 * c + 409 * e + 128);
            return px;
        endfunction

        function void note_input(ytb_pkg::t_in_item item);
            int                 y0, y1, u, v;
            ytb_pkg::t_bgr      px_a, px_b;
            ytb_pkg::t_out_item want;
            if (pixel_format[ytb_pkg::FMT_NV12_BIT]) begin
                y0 = item.byte_zero; y1 = item.byte_one;
                u  = item.byte_two;  v  = item.byte_three;
            end else if (pixel_format == ytb_pkg::FMT_UYVY) begin
                u  = item.byte_zero; y0 = item.byte_one;
                v  = item.byte_two;  y1 = item.byte_three;
            end else begin
                y0 = item.byte_zero; u  = item.byte_one;
                y1 = item.byte_two;  v  = item.byte_three;
            end
            px_a = pixel_bgr(y0, u - 128, v - 128);
            px_b = pixel_bgr(y1, u - 128, v - 128);
            want = '0;
            want.blue_first  = px_a.blue;
            want.green_first = px_a.green;
            want.red_first   = px_a.red;
            if (item.second_present) begin
                want.blue_second  = px_b.blue;
                want.green_second = px_b.green;
                want.red_second   = px_b.red;
                want.second_valid = 1'b1;
            end else begin
                n_lone++;
            end
            pending_pairs.push_back(want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(ytb_pkg::t_out_item got);
            ytb_pkg::t_out_item want;
            if (pending_pairs.size() == 0) begin
                $error("pixel pair with nothing pending: %h", got);
                errors++;
                return;
            end
            want = pending_pairs.pop_front();
            n_checked++;
            compare_field("blue_first",   want.blue_first,   got.blue_first);
            compare_field("green_first",  want.green_first,  got.green_first);
            compare_field("red_first",    want.red_first,    got.red_first);
            compare_field("blue_second",  want.blue_second,  got.blue_second);
            compare_field("green_second", want.green_second, got.green_second);
            compare_field("red_second",   want.red_second,   got.red_second);
            compare_field("second_valid", want.second_valid, got.second_valid);
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ytb_pkg::PADDR_W-1:0] paddr;
    logic [ytb_pkg::PDATA_W-1:0] pwdata;
    logic [ytb_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    bit                src_idle_on;
    bit                sink_idle_on;
    int                stall_left;
    ytb_pkg::t_in_item corner_items[6];
    logic [1:0]        phase_fmt[4];
    pair_scoreboard    sb;

    ytb_in_if  in_pix();
    ytb_out_if out_pix();

    yuv_to_bgra_pixel_pair DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (in_pix),
        .o_pix   (out_pix),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic write_pixel_format(input logic [1:0] fmt);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ytb_pkg::ADDR_PIXEL_FORMAT;
        pwdata  <= ytb_pkg::PDATA_W'(fmt);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.pixel_format = fmt;
    endtask

    task automatic send_pair(input ytb_pkg::t_in_item item);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            in_pix.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_pix.valid <= 1'b1;
        in_pix.data  <= item;
        do @(posedge i_clk); while (!in_pix.ready);
        sb.note_input(item);
    endtask

    function automatic ytb_pkg::t_in_item random_pair();
        logic [7:0] corner[7];
        logic [7:0] b[4];
        corner = '{8'd0, 8'd1, 8'd16, 8'd128, 8'd235, 8'd254, 8'd255};
        // lean toward clamp and offset corners now and then
        for (int k = 0; k < 4; k++) begin
            b[k] = ($urandom_range(0, 7) == 0) ? corner[$urandom_range(0, 6)]
                                                : 8'($urandom_range(0, 255));
        end
        return {b[0], b[1], b[2], b[3], 1'($urandom_range(0, 3) != 0)};
    endfunction

    task automatic wait_drained();
        while (sb.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (ytb_pkg::NUM_STAGES + 2) @(posedge i_clk);
    endtask

    // Output side: check every transfer, stall in random bursts
    initial begin
        out_pix.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_pix.valid && out_pix.ready) begin
                sb.check_result(out_pix.data);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_pix.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                out_pix.ready <= 1'b0;
            end else begin
                out_pix.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [1:0] fmt;
        sb = new();
        i_rst_n      <= 1'b0;
        in_pix.valid <= 1'b0;
        in_pix.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        corner_items = '{
            {8'h00, 8'h00, 8'h00, 8'h00, 1'b1},   // everything low
            {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},   // everything high
            {8'h10, 8'h80, 8'h10, 8'h80, 1'b1},   // black in packed order
            {8'hEB, 8'h80, 8'hEB, 8'h80, 1'b1},   // white in packed order
            {8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1},   // opposing chroma extremes
            {8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0}    // lone pixel, busy bytes
        };
        phase_fmt = '{ytb_pkg::FMT_YUYV, ytb_pkg::FMT_UYVY, FMT_NV12, FMT_SPARE};
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= NUM_PHASES - CALM_PHASES) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            fmt = (p < 4) ? phase_fmt[p] : 2'($urandom_range(0, 3));
            write_pixel_format(fmt);
            if (p < 4) begin
                foreach (corner_items[k]) send_pair(corner_items[k]);
            end
            repeat (RANDOM_PER_PHASE) send_pair(random_pair());
            in_pix.valid <= 1'b0;
            // hold the sender until the pipeline has emptied
            wait_drained();
        end

        $display("Checked %0d pixel pairs, %0d of them with the second pixel absent",
                 sb.n_checked, sb.n_lone);
        $display("Ran %0d format phases covering every byte order and the spare code",
                 NUM_PHASES);
        if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
